// File: hdl/mclm_pkg.sv
// Shared types, constants and helpers of the multi-channel line merger.
// Used by the controller, datapath and top level under hdl/; depends on nothing else.
package mclm_pkg;

	localparam int DEF_CHANNELS   = 4;
	localparam int DEF_RING_DEPTH = 64;

	// Fixed field widths
	localparam int CH_W     = 2;
	localparam int CH_MAX   = 4;
	localparam int BYTE_W   = 8;
	localparam int NAME_W   = 64;
	localparam int NAME_LEN = 8;
	localparam int CNT_W    = 4;
	localparam int CFG_IDX_W = 3;
	localparam int EN_W     = 4;

	// Character codes
	localparam logic [BYTE_W-1:0] CHAR_LF     = 8'd10;
	localparam logic [BYTE_W-1:0] CHAR_CR     = 8'd13;
	localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_ENABLE = 3'd0,
		REG_CHANNEL_NAME_0 = 3'd1,
		REG_CHANNEL_NAME_1 = 3'd2,
		REG_CHANNEL_NAME_2 = 3'd3,
		REG_CHANNEL_NAME_3 = 3'd4
	} reg_index_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic push;
		logic lock;
		logic pop;
		logic load_char;
		logic shift;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_push;
		logic locked;
		logic found;
		logic name_empty;
		logic ring_nonempty;
		logic last;
	} dp_status_t;

	function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
		logic [BYTE_W-1:0] r;
		if (nib < 4'd10)
			r = 8'h30 + {4'd0, nib};
		else
			r = 8'h37 + {4'd0, nib};
		return r;
	endfunction

	// Count of leading non-zero bytes, first char in the low byte.
	function automatic logic [CNT_W-1:0] name_length(input logic [NAME_W-1:0] nm);
		logic [CNT_W-1:0] len;
		len = CNT_W'(NAME_LEN);
		for (int i = NAME_LEN - 1; i >= 0; i--) begin
			if (nm[i*BYTE_W +: BYTE_W] == '0)
				len = CNT_W'(i);
		end
		return len;
	endfunction

endpackage

// File: hdl/mclm_ram.sv
// Generic single-clock RAM, one write port and one read port, registered read.
// Standalone; no package needed.
module mclm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

// File: hdl/mclm_ctrl.sv
// Sequencing state machine of the line merger: decode, ring read, result emission.
// Depends on mclm_pkg for the command and status structs.
module mclm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	output logic                result_valid,
	input  logic                result_stall,
	input  mclm_pkg::dp_status_t status,
	output mclm_pkg::ctrl_cmd_t  cmd
);

	import mclm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECODE = 4'b0010,
		S_READ   = 4'b0100,
		S_EMIT   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		item_stall   = 1'b1;
		result_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				if (status.is_push) begin
					cmd.push = 1'b1;
				end else if (!status.locked) begin
					if (status.found) begin
						cmd.lock = 1'b1;
						if (!status.name_empty)
							state_d = S_EMIT;
					end
				end else if (status.ring_nonempty) begin
					cmd.pop = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.load_char = 1'b1;
				state_d       = S_EMIT;
			end
			S_EMIT: begin
				result_valid = 1'b1;
				if (!result_stall) begin
					cmd.shift = 1'b1;
					if (status.last)
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// File: hdl/mclm_dp.sv
// Datapath of the line merger: configuration, ring indexes, ring store, scan,
// escape encoding and the output character buffer. Uses mclm_pkg and mclm_ram.
module mclm_dp #(
	parameter int CHANNELS   = mclm_pkg::DEF_CHANNELS,
	parameter int RING_DEPTH = mclm_pkg::DEF_RING_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mclm_pkg::ctrl_cmd_t                  cmd,
	output mclm_pkg::dp_status_t                 status,
	input  logic                                 cfg_we,
	input  logic [mclm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mclm_pkg::NAME_W-1:0]          cfg_data,
	input  logic                                 operation,
	input  logic [mclm_pkg::CH_W-1:0]            channel,
	input  logic [mclm_pkg::BYTE_W-1:0]          data_byte,
	output logic [mclm_pkg::BYTE_W-1:0]          out_byte,
	output logic [mclm_pkg::CH_W-1:0]            source_channel,
	output logic                                 last_of_run
);

	import mclm_pkg::*;

	localparam int IDX_W  = $clog2(RING_DEPTH);
	localparam int DEPTH  = CHANNELS * RING_DEPTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(RING_DEPTH - 1);
	localparam logic [ADDR_W-1:0] STRIDE    = ADDR_W'(RING_DEPTH);
	localparam logic [CH_W:0]     CH_COUNT  = (CH_W+1)'(CHANNELS);

	// Configuration
	logic [EN_W-1:0]   enable_q;
	logic [NAME_W-1:0] name_q [CH_MAX];

	// Ring and merger state
	logic [IDX_W-1:0] wr_idx_q [CH_MAX];
	logic [IDX_W-1:0] rd_idx_q [CH_MAX];
	logic             locked_q;
	logic [CH_W-1:0]  ptr_q;

	// Captured item and output buffer
	op_t                   op_q;
	logic [CH_W-1:0]       ch_q;
	logic [BYTE_W-1:0]     byte_q;
	logic [NAME_W-1:0]     buf_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CH_W-1:0]       out_ch_q;

	logic [IDX_W-1:0]  wr_next, rd_next;
	logic              push_ok;
	logic              found;
	logic [CH_W-1:0]   found_ch;
	logic [CH_W-1:0]   ptr_next;
	logic [BYTE_W-1:0] ram_rdata;
	logic              pass_through;
	logic [NAME_W-1:0] esc_buf;

	function automatic logic [ADDR_W-1:0] addr_of(input logic [CH_W-1:0] ch,
		input logic [IDX_W-1:0] idx);
		return ADDR_W'(ch) * STRIDE + ADDR_W'(idx);
	endfunction

	assign wr_next  = (wr_idx_q[ch_q] == IDX_LAST) ? '0 : wr_idx_q[ch_q] + 1'b1;
	assign rd_next  = (rd_idx_q[ptr_q] == IDX_LAST) ? '0 : rd_idx_q[ptr_q] + 1'b1;
	assign ptr_next = (ptr_q == CH_W'(CHANNELS - 1)) ? '0 : ptr_q + 1'b1;
	assign push_ok  = ({1'b0, ch_q} < CH_COUNT) && enable_q[ch_q] &&
		(wr_next != rd_idx_q[ch_q]);

	// Round-robin scan from the pointer; lowest offset wins
	always_comb begin
		found    = 1'b0;
		found_ch = '0;
		for (int k = CHANNELS - 1; k >= 0; k--) begin
			logic [CH_W:0]   sum;
			logic [CH_W-1:0] cand;
			sum  = {1'b0, ptr_q} + (CH_W+1)'(k);
			cand = (sum >= CH_COUNT) ? CH_W'(sum - CH_COUNT) : sum[CH_W-1:0];
			if (enable_q[cand] && (rd_idx_q[cand] != wr_idx_q[cand])) begin
				found    = 1'b1;
				found_ch = cand;
			end
		end
	end

	mclm_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (cmd.push && push_ok),
		.wr_addr (addr_of(ch_q, wr_next)),
		.wr_data (byte_q),
		.rd_en   (cmd.pop),
		.rd_addr (addr_of(ptr_q, rd_next)),
		.rd_data (ram_rdata)
	);

	assign pass_through = (ram_rdata >= CHAR_SPACE) || (ram_rdata == CHAR_LF) ||
		(ram_rdata == CHAR_CR);
	assign esc_buf = {32'd0, CHAR_SPACE, hex_digit(ram_rdata[3:0]),
		hex_digit(ram_rdata[7:4]), CHAR_DOLLAR};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
			for (int i = 0; i < CH_MAX; i++) begin
				name_q[i]   <= '0;
				wr_idx_q[i] <= '0;
				rd_idx_q[i] <= '0;
			end
			locked_q <= 1'b0;
			ptr_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CHANNEL_ENABLE: enable_q  <= cfg_data[EN_W-1:0];
					REG_CHANNEL_NAME_0: name_q[0] <= cfg_data;
					REG_CHANNEL_NAME_1: name_q[1] <= cfg_data;
					REG_CHANNEL_NAME_2: name_q[2] <= cfg_data;
					REG_CHANNEL_NAME_3: name_q[3] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.push && push_ok)
				wr_idx_q[ch_q] <= wr_next;
			if (cmd.lock) begin
				locked_q <= 1'b1;
				ptr_q    <= found_ch;
			end
			if (cmd.pop)
				rd_idx_q[ptr_q] <= rd_next;
			if (cmd.load_char && (ram_rdata == CHAR_LF)) begin
				locked_q <= 1'b0;
				ptr_q    <= ptr_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op_t'(operation);
			ch_q   <= channel;
			byte_q <= data_byte;
		end
		if (cmd.lock) begin
			buf_q    <= name_q[found_ch];
			cnt_q    <= name_length(name_q[found_ch]);
			out_ch_q <= found_ch;
		end else if (cmd.load_char) begin
			buf_q    <= pass_through ? {56'd0, ram_rdata} : esc_buf;
			cnt_q    <= pass_through ? CNT_W'(1) : CNT_W'(4);
			out_ch_q <= ptr_q;
		end else if (cmd.shift) begin
			buf_q <= buf_q >> BYTE_W;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign status.is_push       = (op_q == OP_PUSH);
	assign status.locked        = locked_q;
	assign status.found         = found;
	assign status.name_empty    = (name_length(name_q[found_ch]) == '0);
	assign status.ring_nonempty = (rd_idx_q[ptr_q] != wr_idx_q[ptr_q]);
	assign status.last          = (cnt_q == CNT_W'(1));

	assign out_byte       = buf_q[BYTE_W-1:0];
	assign source_channel = out_ch_q;
	assign last_of_run    = status.last;

endmodule

// File: hdl/multi_channel_line_merger.sv
// Top level of the multi-channel line merger: controller plus datapath.
// Depends on mclm_pkg, mclm_ctrl, mclm_dp (and mclm_ram through mclm_dp).
//
//  port group   direction  handshake               payload
//  item         in         item_valid/item_stall   operation, channel, data_byte
//  result       out        result_valid/stall      out_byte, source_channel, last_of_run
//  cfg          in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One item is in flight at a time. A push, or a tick that finds nothing to do, is
// captured, decoded and done; a tick that locks then emits the channel name; a tick
// that pops passes through a read state for the registered read of the ring store
// and then emits the byte, plain or as a four-character escape. Result stalls hold
// the emission. Reset is asynchronous and clears configuration, ring indexes and the
// lock; the ring store itself needs no clearing since only written slots are read.
module multi_channel_line_merger #(
	parameter int CHANNELS   = mclm_pkg::DEF_CHANNELS,
	parameter int RING_DEPTH = mclm_pkg::DEF_RING_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input transactions
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic                           operation,
	input  logic [mclm_pkg::CH_W-1:0]      channel,
	input  logic [mclm_pkg::BYTE_W-1:0]    data_byte,
	// result transactions
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [mclm_pkg::BYTE_W-1:0]    out_byte,
	output logic [mclm_pkg::CH_W-1:0]      source_channel,
	output logic                           last_of_run,
	// register writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mclm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mclm_pkg::NAME_W-1:0]    cfg_data
);

	import mclm_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Registers are plain flops; a write always completes in its cycle.
	assign cfg_ready = 1'b1;

	// Controller: hold the input while busy, advance through decode/read/emit.
	mclm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// Datapath: rings, scan, escape encoding and the output buffer.
	mclm_dp #(
		.CHANNELS   (CHANNELS),
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.operation      (operation),
		.channel        (channel),
		.data_byte      (data_byte),
		.out_byte       (out_byte),
		.source_channel (source_channel),
		.last_of_run    (last_of_run)
	);

	// An accepted transaction is decoded first; no result shows in the next cycle.
	a_no_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> !result_valid)
		else $error("result shown right after an input transaction");

	// No new input while results are still being delivered.
	a_stall_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("input taken while results pending");

	// The run ends at the transaction marked last.
	a_run_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && last_of_run |=> !result_valid)
		else $error("result shown after the last of a run");

	// Within a run the source channel holds.
	a_channel_steady: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !last_of_run |=> $stable(source_channel))
		else $error("source channel changed within a run");

endmodule
